/* sv/ipv4_longest_prefix_router_assert.svh */
// Assertion macros shared by the router RTL.
`ifndef IPV4_LONGEST_PREFIX_ROUTER_ASSERT_SVH
`define IPV4_LONGEST_PREFIX_ROUTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("router assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("router assertion failed");

`endif

/* sv/ipv4lpm_pkg.sv */
`default_nettype none

package ipv4lpm_pkg;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int TTL_W    = 8;
    localparam int IFACE_W  = 3;
    localparam int STATUS_W = 3;

    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(32);
    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [TTL_W-1:0]  TTL_MIN  = TTL_W'(1);

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_ROUTE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FORWARD = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TTL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOROUTE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   rt_prefix;
        logic [LEN_W-1:0]    rt_len;
        logic                hop_present;
        logic [ADDR_W-1:0]   hop_address;
        logic [IFACE_W-1:0]  interface_index;
        logic [ADDR_W-1:0]   dest_address;
        logic [TTL_W-1:0]    ttl_in;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IFACE_W-1:0]  out_interface;
        logic [ADDR_W-1:0]   next_hop_out;
        logic [TTL_W-1:0]    ttl_out;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   length;
        logic               hop_present;
        logic [ADDR_W-1:0]  hop;
        logic [IFACE_W-1:0] port;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic ready;
        logic start;
        logic scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_busy;
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] len_mask(logic [LEN_W-1:0] len);
        return ~(ALL_ONES >> len);
    endfunction

endpackage

`default_nettype wire

/* sv/ipv4lpm_ctrl.sv */
`default_nettype none

module ipv4lpm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ipv4lpm_pkg::t_sts i_sts,
    output ipv4lpm_pkg::t_cmd      o_cmd
);

    ipv4lpm_pkg::t_state r_state;
    ipv4lpm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4lpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ipv4lpm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.need_scan ? ipv4lpm_pkg::S_SCAN : ipv4lpm_pkg::S_FINISH;
                end
            end
            ipv4lpm_pkg::S_SCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = ipv4lpm_pkg::S_FINISH;
                end
            end
            ipv4lpm_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ipv4lpm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ipv4lpm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ipv4lpm_pkg::S_IDLE: begin
                o_cmd.ready = 1'b1;
                o_cmd.start = i_valid;
            end
            ipv4lpm_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ipv4lpm_pkg::S_FINISH: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/ipv4lpm_dp.sv */
`default_nettype none

`include "ipv4_longest_prefix_router_assert.svh"

module ipv4lpm_dp #(
    parameter int ROUTES = 16,
    parameter int PORTS  = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ipv4lpm_pkg::t_in i_data,
    input  wire logic             i_ready,
    input  wire ipv4lpm_pkg::t_cmd i_cmd,
    output ipv4lpm_pkg::t_sts     o_sts,
    output logic                  o_valid,
    output ipv4lpm_pkg::t_out     o_data
);

    localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CW = $clog2(ROUTES + 1);
    localparam logic [CW-1:0] ROUTES_C = CW'(ROUTES);

    ipv4lpm_pkg::t_entry r_mem [ROUTES];
    ipv4lpm_pkg::t_entry r_rd_data;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_issue;
    logic          r_cmp_valid;

    logic                               r_kind;
    logic                               r_full;
    logic [ipv4lpm_pkg::ADDR_W-1:0]     r_dest;
    logic [ipv4lpm_pkg::TTL_W-1:0]      r_ttl;

    logic                               r_found;
    logic [ipv4lpm_pkg::LEN_W-1:0]      r_best_len;
    logic [ipv4lpm_pkg::IFACE_W-1:0]    r_best_port;
    logic                               r_best_hop_present;
    logic [ipv4lpm_pkg::ADDR_W-1:0]     r_best_hop;

    logic              r_out_valid;
    ipv4lpm_pkg::t_out r_out;
    ipv4lpm_pkg::t_out n_out;

    logic [ipv4lpm_pkg::IFACE_W-1:0] w_port_tbl [8];
    logic [ipv4lpm_pkg::LEN_W-1:0]   w_len;
    ipv4lpm_pkg::t_entry             w_entry;
    logic                            w_wr_en;
    logic                            w_issue;
    logic                            w_match;
    logic                            w_better;
    logic                            w_out_fwd;
    logic                            w_out_quiet;

    for (genvar g = 0; g < 8; g++) begin : g_port_tbl
        assign w_port_tbl[g] = ipv4lpm_pkg::IFACE_W'(g % PORTS);
    end

    always_comb begin
        w_len = (i_data.rt_len > ipv4lpm_pkg::MAX_LEN) ?
                ipv4lpm_pkg::MAX_LEN : i_data.rt_len;
        w_entry.prefix      = i_data.rt_prefix & ipv4lpm_pkg::len_mask(w_len);
        w_entry.length      = w_len;
        w_entry.hop_present = i_data.hop_present;
        w_entry.hop         = i_data.hop_present ? i_data.hop_address : '0;
        w_entry.port        = w_port_tbl[i_data.interface_index];
    end

    assign w_wr_en  = i_cmd.start && (i_data.kind == ipv4lpm_pkg::KIND_ADD) &&
                      (r_count < ROUTES_C);
    assign w_issue  = i_cmd.scan && (r_issue < r_count);
    assign w_match  = (r_dest & ipv4lpm_pkg::len_mask(r_rd_data.length)) == r_rd_data.prefix;
    assign w_better = !r_found || (r_rd_data.length >= r_best_len);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IW-1:0]] <= w_entry;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_issue[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.start) begin
                r_issue     <= '0;
                r_cmp_valid <= 1'b0;
                r_found     <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_issue <= r_issue + CW'(1);
                end
                r_cmp_valid <= w_issue;
                if (r_cmp_valid && w_match && w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind <= i_data.kind;
            r_full <= (r_count >= ROUTES_C);
            r_dest <= i_data.dest_address;
            r_ttl  <= i_data.ttl_in;
        end
        if (!i_cmd.start && r_cmp_valid && w_match && w_better) begin
            r_best_len         <= r_rd_data.length;
            r_best_port        <= r_rd_data.port;
            r_best_hop_present <= r_rd_data.hop_present;
            r_best_hop         <= r_rd_data.hop;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_out = '0;
        if (r_kind == ipv4lpm_pkg::KIND_ADD) begin
            n_out.status = r_full ? ipv4lpm_pkg::ST_FULL : ipv4lpm_pkg::ST_STORED;
        end else if (r_ttl <= ipv4lpm_pkg::TTL_MIN) begin
            n_out.status = ipv4lpm_pkg::ST_TTL;
        end else if (!r_found) begin
            n_out.status = ipv4lpm_pkg::ST_NOROUTE;
        end else begin
            n_out.status        = ipv4lpm_pkg::ST_FORWARD;
            n_out.out_interface = r_best_port;
            n_out.next_hop_out  = r_best_hop_present ? r_best_hop : r_dest;
            n_out.ttl_out       = r_ttl - ipv4lpm_pkg::TTL_MIN;
        end
    end

    always_comb begin
        o_sts.need_scan = (i_data.kind == ipv4lpm_pkg::KIND_ROUTE) &&
                          (i_data.ttl_in > ipv4lpm_pkg::TTL_MIN);
        o_sts.scan_busy = (r_issue < r_count) || r_cmp_valid;
        o_sts.out_free  = !r_out_valid || i_ready;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign w_out_fwd   = r_out_valid && (r_out.status == ipv4lpm_pkg::ST_FORWARD);
    assign w_out_quiet = (r_out.out_interface == '0) && (r_out.next_hop_out == '0) &&
                         (r_out.ttl_out == '0);

    `LPM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ROUTES_C)
    `LPM_ASSERT_NEXT(a_count_only_on_add, i_clk, i_rst_n, !w_wr_en, $stable(r_count))
    `LPM_ASSERT_NOW(a_forward_ttl, i_clk, i_rst_n, w_out_fwd, r_out.ttl_out != '0)
    `LPM_ASSERT_NOW(a_quiet_fields, i_clk, i_rst_n, r_out_valid && !w_out_fwd, w_out_quiet)

endmodule

`default_nettype wire

/* sv/ipv4_longest_prefix_router.sv */
// IPv4 longest-prefix router with a table of ROUTES entries held in a single-port memory.
// An add beat stores one route, or answers table full, and a datagram with a TTL of 0 or 1
// is dropped without a table scan; each of these goes straight to the output stage. A lookup
// reads the stored routes one per cycle from the memory and keeps the longest match, and
// its result then goes to the output register. A finished result waits in that register,
// and the next beat is taken while it waits; a further result waits until it is taken.
`default_nettype none

module ipv4_longest_prefix_router #(
    parameter int ROUTES = 16,
    parameter int PORTS  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ipv4lpm_pkg::t_in  i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ipv4lpm_pkg::t_out      o_data
);

    ipv4lpm_pkg::t_cmd w_cmd;
    ipv4lpm_pkg::t_sts w_sts;

    ipv4lpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ipv4lpm_dp #(
        .ROUTES (ROUTES),
        .PORTS  (PORTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_ready (i_ready),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    assign o_ready = w_cmd.ready;

endmodule

`default_nettype wire

/* sim/ipv4_lpm_forward_check.sv */
module ipv4_lpm_forward_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  ipv4lpm_pkg::t_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  ipv4lpm_pkg::t_out i_out_data,
    output int unsigned       o_errors,
    output int unsigned       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTE_SLOTS = 16;

    ipv4lpm_pkg::t_entry route_table [ROUTE_SLOTS];
    int unsigned         route_count;
    ipv4lpm_pkg::t_out   verdict_q [$];
    int unsigned         errs;

    function automatic logic [ipv4lpm_pkg::ADDR_W-1:0] prefix_mask(
            logic [ipv4lpm_pkg::LEN_W-1:0] plen);
        logic [ipv4lpm_pkg::LEN_W-1:0] n;
        n = (plen > ipv4lpm_pkg::MAX_LEN) ? ipv4lpm_pkg::MAX_LEN : plen;
        if (n == '0) begin
            return '0;
        end
        return ipv4lpm_pkg::ALL_ONES << (ipv4lpm_pkg::ADDR_W - int'(n));
    endfunction

    function automatic ipv4lpm_pkg::t_out forward_or_store(ipv4lpm_pkg::t_in beat);
        ipv4lpm_pkg::t_out             r;
        logic [ipv4lpm_pkg::LEN_W-1:0] plen;
        logic                          found;
        logic [ipv4lpm_pkg::LEN_W-1:0] best_len;
        int                            best;
        r = '0;
        found = 1'b0;
        best_len = '0;
        best = 0;
        if (beat.kind == ipv4lpm_pkg::KIND_ADD) begin
            if (route_count >= ROUTE_SLOTS) begin
                r.status = ipv4lpm_pkg::ST_FULL;
            end else begin
                plen = (beat.rt_len > ipv4lpm_pkg::MAX_LEN) ? ipv4lpm_pkg::MAX_LEN
                                                            : beat.rt_len;
                route_table[route_count].prefix = beat.rt_prefix & prefix_mask(plen);
                route_table[route_count].length = plen;
                route_table[route_count].hop_present = beat.hop_present;
                route_table[route_count].hop = beat.hop_present ? beat.hop_address : '0;
                route_table[route_count].port = beat.interface_index;
                route_count++;
                r.status = ipv4lpm_pkg::ST_STORED;
            end
        end else if (beat.ttl_in <= ipv4lpm_pkg::TTL_MIN) begin
            r.status = ipv4lpm_pkg::ST_TTL;
        end else begin
            for (int i = 0; i < int'(route_count); i++) begin
                if ((beat.dest_address & prefix_mask(route_table[i].length))
                        == route_table[i].prefix
                        && (!found || route_table[i].length >= best_len)) begin
                    found = 1'b1;
                    best_len = route_table[i].length;
                    best = i;
                end
            end
            if (!found) begin
                r.status = ipv4lpm_pkg::ST_NOROUTE;
            end else begin
                r.status = ipv4lpm_pkg::ST_FORWARD;
                r.out_interface = route_table[best].port;
                r.next_hop_out = route_table[best].hop_present ? route_table[best].hop
                                                                : beat.dest_address;
                r.ttl_out = beat.ttl_in - 8'd1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        ipv4lpm_pkg::t_out want;
        if (!i_rst_n) begin
            route_count = 0;
            verdict_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat arrived with no result expected");
                    errs++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_out_data.status);
                        errs++;
                    end
                    if (i_out_data.out_interface !== want.out_interface) begin
                        $error("out_interface: expected %0d, got %0d",
                               want.out_interface, i_out_data.out_interface);
                        errs++;
                    end
                    if (i_out_data.next_hop_out !== want.next_hop_out) begin
                        $error("next_hop_out: expected %08h, got %08h",
                               want.next_hop_out, i_out_data.next_hop_out);
                        errs++;
                    end
                    if (i_out_data.ttl_out !== want.ttl_out) begin
                        $error("ttl_out: expected %0d, got %0d",
                               want.ttl_out, i_out_data.ttl_out);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                verdict_q.insert(verdict_q.size(), forward_or_store(i_in_data));
            end
        end
        o_errors <= errs;
        o_pending <= verdict_q.size();
    end

endmodule

/* sim/ipv4_longest_prefix_router_tb.sv */
module ipv4_longest_prefix_router_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTE_SLOTS  = 16;
    localparam int ITEMS        = 1700;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    ipv4lpm_pkg::t_in  in_data;
    logic              out_valid;
    logic              out_ready;
    ipv4lpm_pkg::t_out out_data;
    int unsigned       chk_errors;
    int unsigned       chk_pending;
    int unsigned       cycles;
    bit                hold_off_req;
    int                burst_left;

    logic [ipv4lpm_pkg::ADDR_W-1:0] table_prefix [$];
    logic [ipv4lpm_pkg::LEN_W-1:0]  table_len [$];

    ipv4_longest_prefix_router u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    ipv4_lpm_forward_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("ipv4_longest_prefix_router regression: fail");
            $finish;
        end
    end

    function automatic logic [ipv4lpm_pkg::ADDR_W-1:0] lead_ones(int n);
        return (n == 0) ? '0 : ipv4lpm_pkg::ALL_ONES << (ipv4lpm_pkg::ADDR_W - n);
    endfunction

    function automatic ipv4lpm_pkg::t_in add_beat(logic [ipv4lpm_pkg::ADDR_W-1:0] prefix,
                                                  logic [ipv4lpm_pkg::LEN_W-1:0] plen,
                                                  logic hop_on,
                                                  logic [ipv4lpm_pkg::ADDR_W-1:0] hop,
                                                  logic [ipv4lpm_pkg::IFACE_W-1:0] port);
        ipv4lpm_pkg::t_in b;
        b.kind = ipv4lpm_pkg::KIND_ADD;
        b.rt_prefix = prefix;
        b.rt_len = plen;
        b.hop_present = hop_on;
        b.hop_address = hop;
        b.interface_index = port;
        b.dest_address = $urandom;
        b.ttl_in = 8'($urandom);
        return b;
    endfunction

    function automatic ipv4lpm_pkg::t_in route_beat(logic [ipv4lpm_pkg::ADDR_W-1:0] dest,
                                                    logic [ipv4lpm_pkg::TTL_W-1:0] ttl);
        ipv4lpm_pkg::t_in b;
        b.kind = ipv4lpm_pkg::KIND_ROUTE;
        b.rt_prefix = $urandom;
        b.rt_len = 6'($urandom);
        b.hop_present = 1'($urandom);
        b.hop_address = $urandom;
        b.interface_index = 3'($urandom);
        b.dest_address = dest;
        b.ttl_in = ttl;
        return b;
    endfunction

    function automatic ipv4lpm_pkg::t_in random_beat();
        ipv4lpm_pkg::t_in               b;
        int                             j;
        int                             base;
        logic [ipv4lpm_pkg::ADDR_W-1:0] keep;
        b = route_beat($urandom, ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 1))
                                                              : 8'($urandom_range(2, 255)));
        if ($urandom_range(0, (table_len.size() < ROUTE_SLOTS) ? 6 : 11) == 0) begin
            b.kind = ipv4lpm_pkg::KIND_ADD;
            b.rt_len = 6'($urandom_range(0, 32));
            if ($urandom_range(0, 9) == 0) begin
                b.rt_len = 6'($urandom_range(33, 63));
            end else if (table_len.size() > 0 && $urandom_range(0, 1) == 1) begin
                // Nest the new route under a stored one, sometimes at the same length.
                j = $urandom_range(0, table_len.size() - 1);
                base = int'(table_len[j]);
                b.rt_len = 6'($urandom_range(base, 32));
                keep = lead_ones(base);
                b.rt_prefix = (table_prefix[j] & keep) | (b.rt_prefix & ~keep);
            end
        end else if (table_len.size() > 0 && $urandom_range(0, 3) != 0) begin
            j = $urandom_range(0, table_len.size() - 1);
            keep = lead_ones(int'(table_len[j]));
            b.dest_address = (table_prefix[j] & keep) | (b.dest_address & ~keep);
        end
        return b;
    endfunction

    // Called at a falling edge; returns at a falling edge with no pending drive on in_valid.
    task automatic push_beat(ipv4lpm_pkg::t_in beat);
        int gap;
        if (beat.kind == ipv4lpm_pkg::KIND_ADD && table_len.size() < ROUTE_SLOTS) begin
            table_prefix.insert(table_prefix.size(), beat.rt_prefix);
            table_len.insert(table_len.size(),
                             (beat.rt_len > ipv4lpm_pkg::MAX_LEN) ? ipv4lpm_pkg::MAX_LEN
                                                                  : beat.rt_len);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
    endtask

    initial begin : rx_stall
        int mode;
        int span;
        int tick;
        mode = 0;
        span = 0;
        tick = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            tick++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(32, 256);
                end
                span--;
                case (mode)
                    0: begin
                        out_ready <= 1'b1;
                    end
                    1: begin
                        out_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        out_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        out_ready <= (tick % 7) > 2;
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        burst_left = 0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_beat(route_beat(32'h0A00_0001, 8'd64));
        push_beat(route_beat(32'h0A00_0001, 8'd0));
        push_beat(route_beat(32'hFFFF_FFFF, 8'd1));
        push_beat(add_beat(32'h0A12_3456, 6'd8, 1'b1, 32'hC0A8_0001, 3'd3));
        push_beat(route_beat(32'hC000_0001, 8'd200));
        push_beat(route_beat(32'h0A00_0001, 8'd2));
        push_beat(add_beat(32'hDEAD_BEEF, 6'd0, 1'b0, 32'hFFFF_FFFF, 3'd7));
        push_beat(add_beat(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0000_0000, 3'd5));
        push_beat(add_beat(32'h0A0A_0A0A, 6'd40, 1'b0, 32'h1234_5678, 3'd0));
        push_beat(add_beat(32'h0AFF_FFFF, 6'd8, 1'b0, 32'hFFFF_FFFF, 3'd6));
        push_beat(route_beat(32'h0A01_0203, 8'd255));
        push_beat(route_beat(32'hFFFF_FFFF, 8'd2));
        push_beat(route_beat(32'h0A0A_0A0A, 8'd128));
        push_beat(route_beat(32'h0000_0000, 8'd255));
        push_beat(add_beat(32'h0000_0000, 6'd32, 1'b1, 32'hFFFF_FFFF, 3'd1));
        push_beat(route_beat(32'h0000_0000, 8'd3));
        push_beat(add_beat(32'h8000_0000, 6'd1, 1'b1, 32'h7FFF_FFFF, 3'd2));
        push_beat(route_beat(32'hC000_0001, 8'd100));
        push_beat(route_beat(32'h0A0A_0A0B, 8'd255));
        push_beat(add_beat(32'h5555_AAAA, 6'd31, 1'b1, 32'hAAAA_5555, 3'd4));
        push_beat(route_beat(32'h5555_AAAB, 8'd170));

        for (int n = 0; n < ITEMS; n++) begin
            if (n == ITEMS / 3) begin
                hold_off_req = 1'b1;
            end
            if (n == (2 * ITEMS) / 3) begin
                wait_drained();
            end
            push_beat(random_beat());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (chk_errors == 0) begin
            $display("ipv4_longest_prefix_router regression: pass");
        end else begin
            $display("ipv4_longest_prefix_router regression: fail");
        end
        $finish;
    end

endmodule
